// File: sv/sgpl_pkg.sv
// sgpl_pkg: shared widths, reset values, register indexes and controller states
// for the stereo gain peak limiter
// no dependencies
package sgpl_pkg;

  localparam int SMP_W   = 16;  // q1.15 sample and pcm width
  localparam int GAIN_W  = 16;  // q4.12 master gain
  localparam int THR_W   = 16;  // q0.16 threshold
  localparam int REL_W   = 24;  // q0.24 release fraction
  localparam int ENV_W   = 17;  // q1.16 envelope
  localparam int SCL_W   = SMP_W + GAIN_W;   // scaled sample product
  localparam int MAG_W   = SCL_W - 1;        // scaled magnitude, always below 2^31
  localparam int THR_SH  = 11;               // threshold aligned to q.27
  localparam int TGT_W   = 16;               // target gain quotient bits
  localparam int OUT_W   = MAG_W + ENV_W;    // magnitude times envelope
  localparam int FULL_SH = 43;               // 1.0 in the output product
  localparam int PCM_SH  = 15;               // 32767 = 2^15 - 1
  localparam int RPR_W   = ENV_W + REL_W;    // release product

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = REL_W;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd10240;
  localparam logic [THR_W-1:0]  THR_RST  = 16'd62259;
  localparam logic [REL_W-1:0]  REL_RST  = 24'd10066;
  localparam logic [ENV_W-1:0]  ENV_ONE  = 17'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_ENV,
    ST_OUTMUL
  } state_t;

endpackage

// File: sv/sgpl_smul.sv
// sgpl_smul: unsigned shift-add multiplier, one multiplier bit per cycle, lsb first
// standalone, no package dependencies
module sgpl_smul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] prod_r;
  logic [A_W:0]       sum;

  assign busy = (cnt_r != '0);
  assign prod = prod_r;

  // partial product added to the upper half, then the whole word shifts right
  assign sum = {1'b0, prod_r[A_W+B_W-1:B_W]} + (prod_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(B_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= {{A_W{1'b0}}, b};
    end else if (busy) begin
      prod_r <= {sum, prod_r[B_W-1:1]};
    end
  end

endmodule

// File: sv/sgpl_div.sv
// sgpl_div: restoring divider, one quotient bit per cycle, msb first
// the initial remainder must be below the divisor; no package dependencies
module sgpl_div #(
  parameter int D_W = 31,
  parameter int Q_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [D_W-1:0] rem_init,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [Q_W-1:0] quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   d_r;
  logic [Q_W-1:0]   quo_r;
  logic [D_W:0]     rem2;
  logic [D_W:0]     diff;
  logic             ge;

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, d_r};
  assign ge   = (rem2 >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(Q_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      d_r   <= divisor;
      quo_r <= '0;
    end else if (busy) begin
      rem_r <= ge ? diff[D_W-1:0] : rem2[D_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

endmodule

// File: sv/stereo_gain_peak_limiter.sv
// stereo_gain_peak_limiter: top level, controller, envelope and output rounding
// depends on sgpl_pkg, sgpl_smul and sgpl_div
//
// usage
//   input channel: in_valid / in_stall with in_left_in, in_right_in (q1.15).
//   result channel: out_valid / out_stall with out_left_out, out_right_out (pcm).
//   config port: cfg_we, cfg_idx, cfg_wdata; 0 master gain, 1 threshold,
//   2 release rate, other indexes ignored. write only while the block is idle.
// operation
//   one item at a time. scaling runs in a bit-serial multiplier per channel,
//   the release step runs alongside in a serial multiplier, a limiting frame
//   adds a serial divide, and the envelope product runs in serial multipliers.
//   a new item is taken only once the last result is in the output register.
// reset
//   registers return to 2.5 gain, 0.95 threshold, 0.0006 release, envelope 1.0;
//   no result pending.
// stall
//   a finished result sits in the output register while the next item is
//   accepted and processed; that item waits in the last multiply step until
//   the output register frees up.
module stereo_gain_peak_limiter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sgpl_pkg::SMP_W-1:0]    in_left_in,
  input  logic signed [sgpl_pkg::SMP_W-1:0]    in_right_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sgpl_pkg::SMP_W-1:0]    out_left_out,
  output logic signed [sgpl_pkg::SMP_W-1:0]    out_right_out,
  input  logic                                 cfg_we,
  input  logic [sgpl_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sgpl_pkg::CFG_W-1:0]           cfg_wdata
);

  import sgpl_pkg::*;

  // output magnitude: clamp to 1.0, then floor(m * 32767 / 2^43)
  function automatic logic [PCM_SH-1:0] pcm_mag(input logic [OUT_W-1:0] m);
    logic ovf;
    logic brw;
    ovf = |m[OUT_W-1:FULL_SH];
    // m * 2^15 - m borrows from the integer part when the low bits shifted up are below m
    brw = {m[FULL_SH-PCM_SH-1:0], {PCM_SH{1'b0}}} < m[FULL_SH-1:0];
    pcm_mag = ovf ? {PCM_SH{1'b1}} : (m[FULL_SH-1:FULL_SH-PCM_SH] - PCM_SH'(brw));
  endfunction

  state_t state_r, state_nxt;

  // configuration
  logic [GAIN_W-1:0] gain_r;
  logic [THR_W-1:0]  thr_r;
  logic [REL_W-1:0]  rel_r;

  // item state
  logic [ENV_W-1:0] env_r, env_nxt;
  logic             sign_l_r, sign_r_r;
  logic             lim_r;

  // result register
  logic                    out_valid_r;
  logic [SMP_W-1:0]        out_left_r, out_right_r;
  logic [SMP_W-1:0]        out_left_nxt, out_right_nxt;

  // control strobes
  logic in_acc, gain_done, env_ready, omul_done, out_load;

  // serial units
  logic [SMP_W-1:0]   mag_l, mag_r;
  logic               gl_busy, gr_busy, rel_busy, div_busy, ol_busy, or_busy;
  logic [SCL_W-1:0]   gl_prod, gr_prod;
  logic [RPR_W-1:0]   rel_prod;
  logic [TGT_W-1:0]   div_q;
  logic [OUT_W-1:0]   ol_prod, or_prod;
  logic [MAG_W-1:0]   peak;
  logic [MAG_W-1:0]   thr27;
  logic               lim;
  logic [ENV_W-1:0]   tgt;
  logic [ENV_W-1:0]   gap;
  logic [PCM_SH-1:0]  q_l, q_r;

  logic gain_start, div_start, omul_start;

  // sample magnitudes; -1.0 maps to 32768
  assign mag_l = in_left_in[SMP_W-1]  ? (~in_left_in + 1'b1)  : in_left_in;
  assign mag_r = in_right_in[SMP_W-1] ? (~in_right_in + 1'b1) : in_right_in;

  assign gap = ENV_ONE - env_r;

  // peak and threshold both in q.27
  assign peak  = (gl_prod[MAG_W-1:0] > gr_prod[MAG_W-1:0]) ? gl_prod[MAG_W-1:0]
                                                            : gr_prod[MAG_W-1:0];
  assign thr27 = MAG_W'({thr_r, {THR_SH{1'b0}}});
  assign lim   = (peak > thr27);

  // instant attack, otherwise release toward 1.0
  assign tgt     = lim_r ? {1'b0, div_q} : ENV_ONE;
  assign env_nxt = (tgt < env_r) ? tgt : (env_r + rel_prod[RPR_W-1:REL_W]);

  assign q_l = pcm_mag(ol_prod);
  assign q_r = pcm_mag(or_prod);
  assign out_left_nxt  = sign_l_r ? (~{1'b0, q_l} + 1'b1) : {1'b0, q_l};
  assign out_right_nxt = sign_r_r ? (~{1'b0, q_r} + 1'b1) : {1'b0, q_r};

  assign gain_done = !gl_busy && !gr_busy;
  assign env_ready = !rel_busy && !div_busy;
  assign omul_done = !ol_busy && !or_busy;

  sgpl_smul #(.A_W(SMP_W), .B_W(GAIN_W)) u_gain_l (
    .clk(clk), .rst_n(rst_n), .start(gain_start), .a(mag_l), .b(gain_r),
    .busy(gl_busy), .prod(gl_prod)
  );

  sgpl_smul #(.A_W(SMP_W), .B_W(GAIN_W)) u_gain_r (
    .clk(clk), .rst_n(rst_n), .start(gain_start), .a(mag_r), .b(gain_r),
    .busy(gr_busy), .prod(gr_prod)
  );

  // release step: floor((1.0 - env) * rate), started with the item
  sgpl_smul #(.A_W(ENV_W), .B_W(REL_W)) u_release (
    .clk(clk), .rst_n(rst_n), .start(gain_start), .a(gap), .b(rel_r),
    .busy(rel_busy), .prod(rel_prod)
  );

  // target gain threshold / peak, only when the peak is over the threshold
  sgpl_div #(.D_W(MAG_W), .Q_W(TGT_W)) u_target (
    .clk(clk), .rst_n(rst_n), .start(div_start), .rem_init(thr27), .divisor(peak),
    .busy(div_busy), .quo(div_q)
  );

  sgpl_smul #(.A_W(MAG_W), .B_W(ENV_W)) u_out_l (
    .clk(clk), .rst_n(rst_n), .start(omul_start), .a(gl_prod[MAG_W-1:0]), .b(env_nxt),
    .busy(ol_busy), .prod(ol_prod)
  );

  sgpl_smul #(.A_W(MAG_W), .B_W(ENV_W)) u_out_r (
    .clk(clk), .rst_n(rst_n), .start(omul_start), .a(gr_prod[MAG_W-1:0]), .b(env_nxt),
    .busy(or_busy), .prod(or_prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        if (gain_done) state_nxt = ST_ENV;
      end
      ST_ENV: begin
        if (env_ready) state_nxt = ST_OUTMUL;
      end
      ST_OUTMUL: begin
        if (omul_done && (!out_valid_r || !out_stall)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall   = 1'b1;
    in_acc     = 1'b0;
    gain_start = 1'b0;
    div_start  = 1'b0;
    omul_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        in_acc     = in_valid;
        gain_start = in_valid;
      end
      ST_GAIN: begin
        div_start = gain_done && lim;
      end
      ST_ENV: begin
        omul_start = env_ready;
      end
      ST_OUTMUL: begin
        out_load = omul_done && (!out_valid_r || !out_stall);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= ENV_ONE;
      gain_r      <= GAIN_RST;
      thr_r       <= THR_RST;
      rel_r       <= REL_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (omul_start) begin
        env_r <= env_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_MASTER_GAIN:    gain_r <= cfg_wdata[GAIN_W-1:0];
          REG_PEAK_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
          REG_RELEASE_RATE:   rel_r  <= cfg_wdata[REL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sign_l_r <= in_left_in[SMP_W-1];
      sign_r_r <= in_right_in[SMP_W-1];
    end
    if (state_r == ST_GAIN && gain_done) begin
      lim_r <= lim;
    end
    if (out_load) begin
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule
